@@ rtl/psu_pkg.sv @@
package psu_pkg;

    localparam int MAX_LINE_BYTES = 16384;
    localparam int ADDR_W         = $clog2(MAX_LINE_BYTES);
    localparam int POS_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int PIX_W          = 3;
    localparam int MAX_PIX        = 4;
    localparam int SEL_W          = $clog2(MAX_PIX);
    localparam int CFG_W          = POS_W;

    typedef enum logic [0:0] {
        CFG_PIXEL_BYTES = 1'b0,
        CFG_LINE_BYTES  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // one word held between the input side and the reconstruction stage
    typedef struct packed {
        logic              is_data;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
        logic              above_zero;
        logic              bad;
        filt_t             filt;
        logic [SEL_W-1:0]  pix_sel;
    } s1_item_t;

endpackage

@@ rtl/psu_ram.sv @@
module psu_ram #(
    parameter int DEPTH  = 16384,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/psu_ctrl.sv @@
module psu_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  psu_pkg::cfg_idx_t         cfg_index,
    input  logic [psu_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,
    input  logic                      s_tuser,
    output logic                      s1_valid,
    output psu_pkg::s1_item_t         s1_item,
    input  logic                      s1_ready,
    output logic                      rd_en,
    output logic [psu_pkg::ADDR_W-1:0] rd_addr
);

    import psu_pkg::*;

    logic [PIX_W-1:0] pix_reg;
    logic [POS_W-1:0] len_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             first_row_reg, first_row_next;
    filt_t            filt_reg, filt_next;
    logic             bad_reg, bad_next;
    logic             s1_valid_reg, s1_valid_next;
    s1_item_t         s1_item_reg, s1_item_next;

    logic [SEL_W-1:0] pix_sel;
    logic [POS_W-1:0] len_eff;
    logic [POS_W-1:0] x_raw;
    logic [POS_W-1:0] x;
    logic             last;
    logic             accept;
    logic             hdr;
    logic             hdr_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= PIX_W'(1);
            len_reg <= POS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PIXEL_BYTES: pix_reg <= cfg_data[PIX_W-1:0];
                CFG_LINE_BYTES:  len_reg <= cfg_data[POS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (pix_reg == '0)
        begin
            pix_sel = '0;
        end
        else if (pix_reg > PIX_W'(MAX_PIX))
        begin
            pix_sel = SEL_W'(MAX_PIX - 1);
        end
        else
        begin
            pix_sel = SEL_W'(pix_reg - PIX_W'(1));
        end

        if (len_reg == '0)
        begin
            len_eff = POS_W'(1);
        end
        else if (len_reg > POS_W'(MAX_LINE_BYTES))
        begin
            len_eff = POS_W'(MAX_LINE_BYTES);
        end
        else
        begin
            len_eff = len_reg;
        end

        x_raw = pos_reg - POS_W'(1);
        x     = (x_raw >= len_eff) ? (len_eff - POS_W'(1)) : x_raw;
        last  = ((x + POS_W'(1)) >= len_eff);
    end

    assign s_tready = !s1_valid_reg || s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign hdr      = s_tuser || (pos_reg == '0);
    assign hdr_bad  = (s_tdata > 8'(FILT_PAETH));

    always_comb
    begin
        pos_next       = pos_reg;
        first_row_next = first_row_reg;
        filt_next      = filt_reg;
        bad_next       = bad_reg;
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;

        if (accept)
        begin
            s1_valid_next           = 1'b1;
            s1_item_next.data       = s_tdata;
            s1_item_next.pix_sel    = pix_sel;
            s1_item_next.addr       = x[ADDR_W-1:0];
            s1_item_next.last       = last;
            s1_item_next.above_zero = first_row_reg;
            s1_item_next.bad        = bad_reg;
            s1_item_next.filt       = filt_reg;
            if (hdr)
            begin
                s1_item_next.is_data = 1'b0;
                if (s_tuser)
                begin
                    first_row_next = 1'b1;
                end
                bad_next  = hdr_bad;
                filt_next = hdr_bad ? FILT_NONE : filt_t'(s_tdata[2:0]);
                pos_next  = POS_W'(1);
            end
            else
            begin
                s1_item_next.is_data = 1'b1;
                if (last)
                begin
                    pos_next       = '0;
                    first_row_next = 1'b0;
                end
                else
                begin
                    pos_next = x + POS_W'(2);
                end
            end
        end
        else if (s1_valid_reg && s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            first_row_reg <= 1'b1;
            filt_reg      <= FILT_NONE;
            bad_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            first_row_reg <= first_row_next;
            filt_reg      <= filt_next;
            bad_reg       <= bad_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign rd_en    = accept && !hdr;
    assign rd_addr  = x[ADDR_W-1:0];

endmodule

@@ rtl/psu_recon.sv @@
module psu_recon (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s1_valid,
    input  psu_pkg::s1_item_t          s1_item,
    output logic                       s1_ready,
    input  logic [7:0]                 rd_data,
    output logic                       wr_en,
    output logic [psu_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    import psu_pkg::*;

    logic [7:0] left_reg [MAX_PIX];
    logic [7:0] ul_reg   [MAX_PIX];
    logic       out_valid_reg, out_valid_next;
    logic [7:0] value_reg;
    logic       eol_reg;
    logic       bad_reg;

    logic [7:0] a, b, c, v;
    logic [8:0] avg_sum;
    logic       move;
    logic       load;

    function automatic logic [7:0] paeth(input logic [7:0] pa, input logic [7:0] pb,
                                          input logic [7:0] pc);
        logic signed [10:0] d_a, d_b, d_c;
        logic [9:0]         m_a, m_b, m_c;
        d_a = 11'(signed'({3'b000, pb})) - 11'(signed'({3'b000, pc}));
        d_b = 11'(signed'({3'b000, pa})) - 11'(signed'({3'b000, pc}));
        d_c = d_a + d_b;
        m_a = d_a[10] ? 10'(-d_a) : d_a[9:0];
        m_b = d_b[10] ? 10'(-d_b) : d_b[9:0];
        m_c = d_c[10] ? 10'(-d_c) : d_c[9:0];
        if (m_a <= m_b && m_a <= m_c)
        begin
            return pa;
        end
        else if (m_b <= m_c)
        begin
            return pb;
        end
        return pc;
    endfunction

    assign s1_ready = !s1_item.is_data || !out_valid_reg || m_tready;
    assign move     = s1_valid && s1_ready;
    assign load     = move && s1_item.is_data;

    always_comb
    begin
        a       = left_reg[s1_item.pix_sel];
        c       = ul_reg[s1_item.pix_sel];
        b       = s1_item.above_zero ? 8'd0 : rd_data;
        avg_sum = {1'b0, a} + {1'b0, b};
        if (s1_item.bad)
        begin
            v = s1_item.data;
        end
        else
        begin
            case (s1_item.filt)
                FILT_SUB:   v = s1_item.data + a;
                FILT_UP:    v = s1_item.data + b;
                FILT_AVG:   v = s1_item.data + avg_sum[8:1];
                FILT_PAETH: v = s1_item.data + paeth(a, b, c);
                default:    v = s1_item.data;
            endcase
        end
    end

    // pixel history: index 0 is the newest byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIX; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (move)
        begin
            if (!s1_item.is_data)
            begin
                for (int i = 0; i < MAX_PIX; i++)
                begin
                    left_reg[i] <= '0;
                    ul_reg[i]   <= '0;
                end
            end
            else
            begin
                for (int i = MAX_PIX - 1; i > 0; i--)
                begin
                    left_reg[i] <= left_reg[i-1];
                    ul_reg[i]   <= ul_reg[i-1];
                end
                left_reg[0] <= v;
                ul_reg[0]   <= b;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= v;
            eol_reg   <= s1_item.last;
            bad_reg   <= s1_item.bad;
        end
    end

    assign wr_en    = load;
    assign wr_addr  = s1_item.addr;
    assign wr_data  = v;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tlast  = eol_reg;
    assign m_tuser  = bad_reg;

`ifndef SYNTHESIS
    a_wr_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> out_valid_reg)
        else $error("line store written without a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && s1_valid && s1_item.is_data) |-> !s1_ready)
        else $error("held result overwritten");

    a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (move && !s1_item.is_data) |=> (left_reg[0] == 8'd0 && ul_reg[0] == 8'd0))
        else $error("history not cleared at line start");

    a_bad_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (load && s1_item.bad) |=> (m_tdata == $past(s1_item.data) && m_tuser))
        else $error("bad-filter word not passed through");
`endif

endmodule

@@ rtl/png_scanline_unfilter.sv @@
// A data word is registered in the control stage and then in the output register.
// Throughput: one word per cycle while m_tready is high, filter-type words included;
// filter words give no result. The line store has one read and one write port; each
// data word reads its upper neighbor at accept and writes its result as it is loaded.
// Reset: control, configuration (1 byte/pixel, 1 byte/line) and pixel history cleared
// at once; the line store is not cleared, the first row of an image reads zero above.
module png_scanline_unfilter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  psu_pkg::cfg_idx_t         cfg_index,
    input  logic [psu_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // [7:0] data
    input  logic                      s_tuser,  // [0] frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,  // [7:0] value
    output logic                      m_tlast,
    output logic                      m_tuser   // [0] bad_filter
);

    import psu_pkg::*;

    logic              s1_valid;
    s1_item_t          s1_item;
    logic              s1_ready;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    psu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .s1_ready  (s1_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    psu_ram #(
        .DEPTH  (MAX_LINE_BYTES),
        .WIDTH  (8),
        .ADDR_W (ADDR_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    psu_recon u_recon (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_ready (s1_ready),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/png_scanline_unfilter_test.sv @@
module png_scanline_unfilter_test;

    import psu_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        logic [7:0] data;
        logic       fs;
    } stream_word_t;

    typedef struct {
        logic [7:0] value;
        logic       eol;
        logic       bad;
    } pixel_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    cfg_idx_t         cfg_index = CFG_PIXEL_BYTES;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             m_tuser;

    stream_word_t pending_words[$];
    pixel_t       expected_pixels[$];
    stream_word_t next_word;
    pixel_t       head_pixel;
    int           words_queued = 0;
    int           words_taken = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;

    // predictor state
    logic [PIX_W-1:0] pix_cfg = PIX_W'(1);
    logic [CFG_W-1:0] len_cfg = CFG_W'(1);
    logic [7:0]       row_above [MAX_LINE_BYTES];
    logic             top_row = 1'b1;
    int               line_pos = 0;
    filt_t            line_filt = FILT_NONE;
    logic             bad_line = 1'b0;
    logic [7:0]       left_hist [MAX_PIX];
    logic [7:0]       upleft_hist [MAX_PIX];

    int pix_plan [NUM_PHASES] = '{1, 3, 4, 0, 7, 2, 5, 6, 4, 3};
    int len_plan [NUM_PHASES] = '{1, 12, 16, 5, 9, 3, 0, 7, 2, 15};

    png_scanline_unfilter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int line_len();
        if (len_cfg == 0)
            return 1;
        if (len_cfg > MAX_LINE_BYTES)
            return MAX_LINE_BYTES;
        return int'(len_cfg);
    endfunction

    task automatic unfilter_byte(input logic [7:0] d, input logic fs);
        int   pix;
        int   len;
        int   x;
        int   a;
        int   b;
        int   c;
        int   v;
        int   p;
        int   da;
        int   db;
        int   dc;
        logic eol_now;
        pix = (pix_cfg == 0) ? 1 : ((pix_cfg > MAX_PIX) ? MAX_PIX : int'(pix_cfg));
        len = line_len();
        if (fs || line_pos == 0)
        begin
            if (fs)
                top_row = 1'b1;
            bad_line = (d > 4);
            line_filt = (d > 4) ? FILT_NONE : filt_t'(d[2:0]);
            foreach (left_hist[i])
            begin
                left_hist[i] = '0;
                upleft_hist[i] = '0;
            end
            line_pos = 1;
        end
        else
        begin
            x = line_pos - 1;
            if (x >= len)
                x = len - 1;
            eol_now = (x + 1 >= len);
            a = left_hist[pix-1];
            c = upleft_hist[pix-1];
            b = top_row ? 0 : int'(row_above[x]);
            if (bad_line)
                v = d;
            else
            begin
                case (line_filt)
                    FILT_SUB:   v = d + a;
                    FILT_UP:    v = d + b;
                    FILT_AVG:   v = d + ((a + b) >> 1);
                    FILT_PAETH:
                    begin
                        p = a + b - c;
                        da = (p > a) ? p - a : a - p;
                        db = (p > b) ? p - b : b - p;
                        dc = (p > c) ? p - c : c - p;
                        if (da <= db && da <= dc)
                            v = d + a;
                        else if (db <= dc)
                            v = d + b;
                        else
                            v = d + c;
                    end
                    default:    v = d;
                endcase
            end
            v = v & 8'hFF;
            for (int i = MAX_PIX - 1; i > 0; i--)
            begin
                left_hist[i] = left_hist[i-1];
                upleft_hist[i] = upleft_hist[i-1];
            end
            left_hist[0] = v[7:0];
            upleft_hist[0] = b[7:0];
            row_above[x] = v[7:0];
            if (eol_now)
            begin
                line_pos = 0;
                top_row = 1'b0;
            end
            else
                line_pos = x + 2;
            expected_pixels.push_back('{value: v[7:0], eol: eol_now, bad: bad_line});
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", msg);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                unfilter_byte(s_tdata, s_tuser);
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.data;
                    s_tuser <= next_word.fs;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    flag_mismatch($sformatf("unexpected word value=%02h", m_tdata));
                else
                begin
                    head_pixel = expected_pixels.pop_front();
                    if (m_tdata !== head_pixel.value)
                        flag_mismatch($sformatf("value %02h, want %02h",
                                                m_tdata, head_pixel.value));
                    if (m_tlast !== head_pixel.eol)
                        flag_mismatch($sformatf("end_of_line %b, want %b",
                                                m_tlast, head_pixel.eol));
                    if (m_tuser !== head_pixel.bad)
                        flag_mismatch($sformatf("bad_filter %b, want %b",
                                                m_tuser, head_pixel.bad));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("png_scanline_unfilter_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_word(input logic [7:0] d, input logic fs);
        pending_words.push_back('{data: d, fs: fs});
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || expected_pixels.size() != 0)
            @(posedge clk);
        // filter words leave no result behind; let the pipe drain
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        if (idx == CFG_PIXEL_BYTES)
            pix_cfg = val[PIX_W-1:0];
        else
            len_cfg = val[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_frames(input int budget);
        int         len;
        int         rows;
        int         cut;
        int         n;
        int         r;
        int         k;
        logic [7:0] f;
        len = line_len();
        n = 0;
        while (n < budget)
        begin
            rows = $urandom_range(1, 5);
            for (r = 0; r < rows; r++)
            begin
                if ($urandom_range(9) == 0)
                    f = 8'($urandom_range(5, 255));
                else
                    f = 8'($urandom_range(4));
                push_word(f, r == 0);
                cut = len;
                if (r == rows - 1 && $urandom_range(7) == 0)
                    cut = $urandom_range(len - 1);
                for (k = 0; k < cut; k++)
                    push_word(random_byte(), $urandom_range(199) == 0);
                n += cut + 1;
            end
        end
    endtask

    // line length cut below the current position while a line is open
    task automatic shrink_mid_line(input int full);
        int done;
        int cut;
        int k;
        done = $urandom_range(1, full - 1);
        cut = $urandom_range(1, done);
        push_word(8'(FILT_SUB), 1'b1);
        for (k = 0; k < full; k++)
            push_word(random_byte(), 1'b0);
        push_word(8'(FILT_PAETH), 1'b0);
        for (k = 0; k < done; k++)
            push_word(random_byte(), 1'b0);
        wait_idle();
        write_reg(CFG_LINE_BYTES, cut);
        push_word(random_byte(), 1'b0);
        push_word(8'(FILT_UP), 1'b0);
        for (k = 0; k < cut; k++)
            push_word(random_byte(), 1'b0);
    endtask

    initial
    begin
        int ph;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_PIXEL_BYTES, 1);
        write_reg(CFG_LINE_BYTES, 2);
        push_word(8'(FILT_SUB), 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'(FILT_UP), 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'(FILT_AVG), 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'h7F, 1'b0);
        push_word(8'(FILT_PAETH), 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'(FILT_NONE), 1'b0);
        push_word(8'h55, 1'b0);
        push_word(8'hAA, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h12, 1'b0);
        push_word(8'hFE, 1'b0);
        push_word(8'h05, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'(FILT_UP), 1'b1);
        push_word(8'h3C, 1'b0);
        push_word(8'(FILT_PAETH), 1'b1);
        push_word(8'hC3, 1'b0);
        push_word(8'h99, 1'b0);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 82; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            write_reg(CFG_PIXEL_BYTES, $urandom_range(4095) * 8 + pix_plan[ph]);
            write_reg(CFG_LINE_BYTES, len_plan[ph]);
            random_frames(130);
            if (ph % 2 == 1 && len_plan[ph] >= 2)
            begin
                wait_idle();
                shrink_mid_line(len_plan[ph]);
            end
        end

        // line length above the store depth, line left open
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_PIXEL_BYTES, 4);
        write_reg(CFG_LINE_BYTES, 32767);
        push_word(8'(FILT_SUB), 1'b1);
        for (k = 0; k < 40; k++)
            push_word(8'($urandom_range(255)), 1'b0);
        wait_idle();
        write_reg(CFG_LINE_BYTES, 6);
        send_idle_pct = 26;
        stall_pct = 26;
        random_frames(60);

        wait_idle();
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("png_scanline_unfilter_test: PASS");
        else
            $display("png_scanline_unfilter_test: FAIL");
        $finish;
    end

endmodule
